/* src/sgr_pkg.sv */
// Shared types, character codes and attribute helpers for the SGR escape parser.
// Depends on nothing; used by ansi_sgr_escape_parser_core.
`default_nettype none

package sgr_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_TEXT = 2'd0;  // plain text
  localparam logic [1:0] PH_ESC  = 2'd1;  // just saw ESC
  localparam logic [1:0] PH_NUM0 = 2'd2;  // list start or after ';'
  localparam logic [1:0] PH_NUM  = 2'd3;  // inside a number

  // Characters of interest
  localparam logic [15:0] CH_ESC    = 16'h001B;
  localparam logic [15:0] CH_LBRACK = 16'h005B;
  localparam logic [15:0] CH_QMARK  = 16'h003F;
  localparam logic [15:0] CH_SEMI   = 16'h003B;
  localparam logic [15:0] CH_FINAL  = 16'h006D;  // 'm'
  localparam logic [15:0] CH_DIG0   = 16'h0030;
  localparam logic [15:0] CH_DIG9   = 16'h0039;

  // SGR codes
  localparam logic [7:0] SGR_RESET    = 8'd0;
  localparam logic [7:0] SGR_BOLD     = 8'd1;
  localparam logic [7:0] SGR_ULINE    = 8'd4;
  localparam logic [7:0] SGR_REV      = 8'd7;
  localparam logic [7:0] SGR_NOBOLD   = 8'd21;
  localparam logic [7:0] SGR_NOULINE  = 8'd24;
  localparam logic [7:0] SGR_NOREV    = 8'd27;
  localparam logic [7:0] SGR_FG_LO    = 8'd30;
  localparam logic [7:0] SGR_FG_HI    = 8'd37;
  localparam logic [7:0] SGR_BG_LO    = 8'd40;
  localparam logic [7:0] SGR_BG_HI    = 8'd47;

  localparam logic [7:0] ACC_MAX = 8'd255;

  // Configuration register indexes
  localparam logic [1:0] REG_DEF_FG    = 2'd0;
  localparam logic [1:0] REG_DEF_BG    = 2'd1;
  localparam logic [1:0] REG_DEF_BOLD  = 2'd2;
  localparam logic [1:0] REG_DEF_ULINE = 2'd3;

  // Reset values of the defaults
  localparam logic [2:0] RST_FG = 3'd7;
  localparam logic [2:0] RST_BG = 3'd0;

  typedef struct packed {
    logic [2:0] fg;
    logic [2:0] bg;
    logic       bold;
    logic       underline;
    logic       reverse;
  } attrs_t;

  // Apply one SGR code to an attribute set; unknown codes leave it as is
  function automatic attrs_t sgr_apply(attrs_t p, logic [7:0] code, attrs_t dflt);
    attrs_t r;
    r = p;
    if (code == SGR_RESET) begin
      r = dflt;
      r.reverse = 1'b0;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      r.fg = code[2:0] - SGR_FG_LO[2:0];
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      r.bg = code[2:0] - SGR_BG_LO[2:0];
    end else if (code == SGR_BOLD || code == SGR_NOBOLD) begin
      r.bold = (code == SGR_BOLD);
    end else if (code == SGR_ULINE || code == SGR_NOULINE) begin
      r.underline = (code == SGR_ULINE);
    end else if (code == SGR_REV || code == SGR_NOREV) begin
      r.reverse = (code == SGR_REV);
    end
    return r;
  endfunction

  // Color index (R in bit 0) to console BGR bits: a bit reversal
  function automatic logic [2:0] color_bits(logic [2:0] idx);
    return {idx[0], idx[1], idx[2]};
  endfunction

  // Console attribute byte from an attribute set
  function automatic logic [7:0] sgr_compose(attrs_t c);
    logic [2:0] f;
    logic [2:0] b;
    f = c.reverse ? c.bg : c.fg;
    b = c.reverse ? c.fg : c.bg;
    return {c.underline, color_bits(b), c.bold, color_bits(f)};
  endfunction

endpackage

`default_nettype wire

/* src/ansi_sgr_escape_parser_core.sv */
// ANSI SGR escape parser: passes text through, turns ESC[...m into attribute bytes.
// Depends on sgr_pkg (types, character codes, apply/compose helpers).
//
//  channel   | dir | payload                                   | beat taken when
//  ----------+-----+-------------------------------------------+-----------------------
//  s_axis    | in  | tdata[15:0] char_in                       | tvalid & tready
//  m_axis    | out | tdata[15:0] text_code, [23:16] attr_byte, | tvalid & tready
//            |     | tuser out_kind                            |
//  cfg       | in  | cfg_idx_i register, cfg_data_i value      | cfg_we_i
//
// One character per cycle sustained while the sink keeps taking results. A beat is
// captured in the input register, parsed from there and its result (if any) lands
// in the output register. The parse stage stalls only while the output register
// holds a result the sink has not taken. Reset clears control state and loads the
// default attributes (fg 7, bg 0, bold/underline/reverse off).
`default_nettype none

module ansi_sgr_escape_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] char_in
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] text_code, [23:16] attr_byte
  output logic             m_axis_tuser,   // [0] out_kind
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [2:0]  cfg_data_i
);

  // Default attribute registers
  logic [2:0] def_fg_q;
  logic [2:0] def_bg_q;
  logic       def_bold_q;
  logic       def_uline_q;
  sgr_pkg::attrs_t dflt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fg_q    <= sgr_pkg::RST_FG;
      def_bg_q    <= sgr_pkg::RST_BG;
      def_bold_q  <= 1'b0;
      def_uline_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgr_pkg::REG_DEF_FG:    def_fg_q    <= cfg_data_i;
        sgr_pkg::REG_DEF_BG:    def_bg_q    <= cfg_data_i;
        sgr_pkg::REG_DEF_BOLD:  def_bold_q  <= cfg_data_i[0];
        sgr_pkg::REG_DEF_ULINE: def_uline_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign dflt = '{fg: def_fg_q, bg: def_bg_q, bold: def_bold_q,
                  underline: def_uline_q, reverse: 1'b0};

  // Input register
  logic        in_valid_q;
  logic [15:0] in_data_q;
  logic        advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  // Parser state
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      acc_q, acc_d;
  logic            seen_q, seen_d;
  sgr_pkg::attrs_t pend_q, pend_d;
  sgr_pkg::attrs_t cur_q, cur_d;

  // Result of the parse step
  logic        res_valid;
  logic        res_kind;
  logic [15:0] res_text;
  logic [7:0]  res_attr;

  logic [11:0]     acc_next;
  sgr_pkg::attrs_t pend_applied;
  logic            is_digit;

  assign is_digit = (in_data_q >= sgr_pkg::CH_DIG0) && (in_data_q <= sgr_pkg::CH_DIG9);
  assign acc_next = {4'b0, acc_q} * 12'd10 + {8'b0, in_data_q[3:0]};
  assign pend_applied = sgr_pkg::sgr_apply(pend_q, acc_q, dflt);

  // One parse step per accepted character
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    pend_d    = pend_q;
    cur_d     = cur_q;
    res_valid = 1'b0;
    res_kind  = 1'b0;
    res_text  = '0;
    res_attr  = '0;
    case (phase_q)
      sgr_pkg::PH_TEXT: begin
        if (in_data_q == sgr_pkg::CH_ESC) begin
          phase_d = sgr_pkg::PH_ESC;
        end else begin
          res_valid = 1'b1;
          res_text  = in_data_q;
        end
      end
      sgr_pkg::PH_ESC: begin
        if (in_data_q == sgr_pkg::CH_LBRACK) begin
          phase_d = sgr_pkg::PH_NUM0;
          acc_d   = '0;
          seen_d  = 1'b0;
          pend_d  = cur_q;
        end else if (in_data_q != sgr_pkg::CH_ESC) begin
          phase_d = sgr_pkg::PH_TEXT;
        end
      end
      default: begin
        if (is_digit) begin
          acc_d   = (acc_next > {4'b0, sgr_pkg::ACC_MAX}) ? sgr_pkg::ACC_MAX : acc_next[7:0];
          phase_d = sgr_pkg::PH_NUM;
        end else if (in_data_q == sgr_pkg::CH_SEMI) begin
          pend_d  = pend_applied;
          seen_d  = 1'b1;
          acc_d   = '0;
          phase_d = sgr_pkg::PH_NUM0;
        end else if (in_data_q != sgr_pkg::CH_QMARK) begin
          // final character closes the list
          phase_d = sgr_pkg::PH_TEXT;
          acc_d   = '0;
          seen_d  = 1'b0;
          if (in_data_q != sgr_pkg::CH_FINAL) begin
            pend_d = cur_q;
          end else begin
            // pending accumulator applies if a number is open; empty list means reset
            if (phase_q == sgr_pkg::PH_NUM || !seen_q) begin
              cur_d = pend_applied;
            end else begin
              cur_d = pend_q;
            end
            pend_d    = cur_d;
            res_valid = 1'b1;
            res_kind  = 1'b1;
            res_attr  = sgr_pkg::sgr_compose(cur_d);
          end
        end
      end
    endcase
  end

  // In the list-start phase the accumulator is always zero, so an empty list
  // applies code 0 through pend_applied as well.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sgr_pkg::PH_TEXT;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      pend_q  <= '{fg: sgr_pkg::RST_FG, bg: sgr_pkg::RST_BG, bold: 1'b0,
                   underline: 1'b0, reverse: 1'b0};
      cur_q   <= '{fg: sgr_pkg::RST_FG, bg: sgr_pkg::RST_BG, bold: 1'b0,
                   underline: 1'b0, reverse: 1'b0};
    end else if (advance) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      pend_q  <= pend_d;
      cur_q   <= cur_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      m_axis_tdata <= {res_attr, res_text};
      m_axis_tuser <= res_kind;
    end
  end

  // Checks
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[15:0] == 16'd0)
                                    : (m_axis_tdata[23:16] == 8'd0)))
    else $error("result fields disagree with out_kind");

  a_text_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == sgr_pkg::PH_TEXT && in_data_q != sgr_pkg::CH_ESC)
    |=> (m_axis_tvalid && !m_axis_tuser))
    else $error("text character not passed through");

  a_idle_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sgr_pkg::PH_TEXT || phase_q == sgr_pkg::PH_ESC)
    |-> (acc_q == 8'd0 && !seen_q))
    else $error("argument state left over outside a list");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q)))
    else $error("held input character changed while stalled");

endmodule

`default_nettype wire
